// ===== hdl/laplacian_sharpen_3x3_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian sharpening core
// Immediate-consequence and next-cycle property forms, clocked on clk_i and
// disabled while rst_ni is low. Defining NO_ASSERTIONS leaves them empty.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_CORE_DEFINES_SVH
`define LAPLACIAN_SHARPEN_3X3_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSH_ASSERT_NOW(lbl, ante, cons, msg)
`define LSH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the Laplacian sharpening core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

  localparam int SampleW      = 8;
  localparam int WidthW       = 11;
  localparam int HeightW      = 13;
  localparam int ChanW        = 3;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 13;
  localparam int SumW         = 12;

  localparam int WidthReset   = 640;
  localparam int HeightReset  = 480;
  localparam int ChanReset    = 3;
  localparam int MinWidth     = 3;
  localparam int MinHeight    = 3;
  localparam int MaxHeight    = 4096;
  localparam int SettleCycles = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth    = 2'd0,
    RegHeight   = 2'd1,
    RegChannels = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdDrain  = 1'b1
  } cmd_e;

  // Per-item control handed from the position tracker to the datapath.
  typedef struct packed {
    logic produce;
    logic border;
    logic last;
  } item_ctl_t;

  // One line buffer word: the two previous rows at the same element column.
  typedef struct packed {
    logic [SampleW-1:0] upper;
    logic [SampleW-1:0] middle;
  } line_pair_t;

  function automatic logic [SampleW-1:0] saturate(input logic [SumW-1:0] sum);
    logic [SampleW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (sum > SumW'(255)) begin
      res = '1;
    end else begin
      res = sum[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lsh_ram.sv =====
// ----------------------------------------------------------------------------
// lsh_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lsh_cfg.sv =====
// ----------------------------------------------------------------------------
// lsh_cfg
// Configuration registers with range clamping, derived row and frame sizes,
// and a short settling hold after every write to a known register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_cfg #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  parameter int ElemsW       = 13,
  parameter int TotalW       = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [lsh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lsh_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic      [lsh_pkg::ChanW-1:0]     ch_o,
  output logic      [lsh_pkg::HeightW-1:0]   rows_o,
  output logic      [ElemsW-1:0]             elems_o,
  output logic      [TotalW-1:0]             total_o,
  output logic                               busy_o,
  output logic                               restart_o
);

  localparam int WidthRst = (lsh_pkg::WidthReset > MAX_WIDTH) ? MAX_WIDTH
                                                             : lsh_pkg::WidthReset;
  localparam int ChanRst  = (lsh_pkg::ChanReset > MAX_CHANNELS) ? MAX_CHANNELS
                                                               : lsh_pkg::ChanReset;
  localparam int ProdW    = lsh_pkg::WidthW + lsh_pkg::ChanW;

  logic [lsh_pkg::WidthW-1:0]  width_q, width_d;
  logic [lsh_pkg::HeightW-1:0] height_q, height_d;
  logic [lsh_pkg::ChanW-1:0]   chan_q, chan_d;
  logic [1:0]                  settle_q, settle_d;
  logic [ElemsW-1:0]           elems_q;
  logic [TotalW-1:0]           total_q;
  logic [lsh_pkg::WidthW-1:0]  w_raw;
  logic [lsh_pkg::HeightW-1:0] h_raw;
  logic [lsh_pkg::ChanW-1:0]   c_raw;
  logic                        known;

  assign w_raw = cfg_data_i[lsh_pkg::WidthW-1:0];
  assign h_raw = cfg_data_i[lsh_pkg::HeightW-1:0];
  assign c_raw = cfg_data_i[lsh_pkg::ChanW-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    chan_d   = chan_q;
    known    = 1'b0;
    if (cfg_valid_i) begin
      case (lsh_pkg::cfg_reg_e'(cfg_index_i))
        lsh_pkg::RegWidth: begin
          known = 1'b1;
          if (32'(w_raw) < 32'(lsh_pkg::MinWidth)) begin
            width_d = lsh_pkg::WidthW'(lsh_pkg::MinWidth);
          end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
            width_d = lsh_pkg::WidthW'(MAX_WIDTH);
          end else begin
            width_d = w_raw;
          end
        end
        lsh_pkg::RegHeight: begin
          known = 1'b1;
          if (32'(h_raw) < 32'(lsh_pkg::MinHeight)) begin
            height_d = lsh_pkg::HeightW'(lsh_pkg::MinHeight);
          end else if (32'(h_raw) > 32'(lsh_pkg::MaxHeight)) begin
            height_d = lsh_pkg::HeightW'(lsh_pkg::MaxHeight);
          end else begin
            height_d = h_raw;
          end
        end
        lsh_pkg::RegChannels: begin
          known = 1'b1;
          if (c_raw == '0) begin
            chan_d = lsh_pkg::ChanW'(1);
          end else if (32'(c_raw) > 32'(MAX_CHANNELS)) begin
            chan_d = lsh_pkg::ChanW'(MAX_CHANNELS);
          end else begin
            chan_d = c_raw;
          end
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end
  end

  // After a known write the sizes settle through elems_q and total_q; items wait.
  always_comb begin
    if (known) begin
      settle_d = 2'(lsh_pkg::SettleCycles);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 2'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lsh_pkg::WidthW'(WidthRst);
      height_q <= lsh_pkg::HeightW'(lsh_pkg::HeightReset);
      chan_q   <= lsh_pkg::ChanW'(ChanRst);
      settle_q <= 2'(lsh_pkg::SettleCycles);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      chan_q   <= chan_d;
      settle_q <= settle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elems_q <= ElemsW'(ProdW'(width_q) * ProdW'(chan_q));
    total_q <= TotalW'(height_q) * TotalW'(elems_q);
  end

  assign ch_o      = chan_q;
  assign rows_o    = height_q;
  assign elems_o   = elems_q;
  assign total_o   = total_q;
  assign busy_o    = (settle_q != '0);
  assign restart_o = known;

endmodule

`default_nettype wire

// ===== hdl/lsh_seq.sv =====
// ----------------------------------------------------------------------------
// lsh_seq
// Input side: raster position tracking, border and frame-end decisions, and
// the line buffer read for each accepted component.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laplacian_sharpen_3x3_core_defines.svh"

module lsh_seq #(
  parameter int AddrW  = 12,
  parameter int ElemsW = 13,
  parameter int TotalW = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [lsh_pkg::SampleW-1:0]   sample_i,
  input  wire logic [lsh_pkg::ChanW-1:0]     ch_i,
  input  wire logic [lsh_pkg::HeightW-1:0]   rows_i,
  input  wire logic [ElemsW-1:0]             elems_i,
  input  wire logic [TotalW-1:0]             total_i,
  input  wire logic                          busy_i,
  input  wire logic                          restart_i,
  input  wire logic                          can_take_i,
  output logic                               item_valid_o,
  output logic      [AddrW-1:0]              item_addr_o,
  output logic      [lsh_pkg::SampleW-1:0]   item_sample_o,
  output lsh_pkg::item_ctl_t                 item_ctl_o
);

  localparam int CmpW = (AddrW > lsh_pkg::ChanW + 1) ? AddrW : lsh_pkg::ChanW + 1;

  logic [AddrW-1:0]            c_q, c_d;
  logic [lsh_pkg::HeightW-1:0] r_q, r_d;
  logic [TotalW-1:0]           emitted_q, emitted_d;
  logic [ElemsW-1:0]           c_inc;
  logic [TotalW-1:0]           emitted_inc;
  logic [CmpW-1:0]             c_ext, ch_ext, ch2_ext;
  logic                        draining, take, produce, border, last;

  assign in_ready_o = !busy_i && can_take_i;
  assign take       = in_valid_i && in_ready_o;
  assign draining   = (r_q >= rows_i);

  // A drain beat before the frame is complete is a bubble.
  assign item_valid_o = take && !((cmd_i == lsh_pkg::CmdDrain) && !draining);

  assign c_ext   = CmpW'(c_q);
  assign ch_ext  = CmpW'(ch_i);
  assign ch2_ext = CmpW'({ch_i, 1'b0});

  assign emitted_inc = emitted_q + TotalW'(1);
  assign produce = ((r_q >= lsh_pkg::HeightW'(1)) && (c_ext >= ch_ext))
                || (r_q >= lsh_pkg::HeightW'(2));
  assign border  = (c_ext < ch2_ext) || (r_q == lsh_pkg::HeightW'(1)) || draining;
  assign last    = produce && (emitted_inc >= total_i);

  assign item_addr_o   = c_q;
  assign item_sample_o = draining ? '0 : sample_i;
  assign item_ctl_o    = '{produce: produce, border: border, last: last};

  assign c_inc = ElemsW'(c_q) + ElemsW'(1);

  always_comb begin
    c_d       = c_q;
    r_d       = r_q;
    emitted_d = emitted_q;
    if (restart_i) begin
      c_d       = '0;
      r_d       = '0;
      emitted_d = '0;
    end else if (item_valid_o) begin
      if (last) begin
        c_d       = '0;
        r_d       = '0;
        emitted_d = '0;
      end else begin
        if (produce) begin
          emitted_d = emitted_inc;
        end
        if (c_inc >= elems_i) begin
          c_d = '0;
          r_d = r_q + lsh_pkg::HeightW'(1);
        end else begin
          c_d = c_inc[AddrW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q       <= '0;
      r_q       <= '0;
      emitted_q <= '0;
    end else begin
      c_q       <= c_d;
      r_q       <= r_d;
      emitted_q <= emitted_d;
    end
  end

  `LSH_ASSERT_NEXT(a_restart_clears, restart_i, (c_q == '0) && (r_q == '0) && (emitted_q == '0), "config write did not restart the frame")
  `LSH_ASSERT_NOW(a_col_in_row, !busy_i, ElemsW'(c_q) < elems_i, "element position beyond row length")

endmodule

`default_nettype wire

// ===== hdl/lsh_dp.sv =====
// ----------------------------------------------------------------------------
// lsh_dp
// Datapath: takes the line buffer word, shifts the neighbour window, writes
// the rows back, forms the sharpened value and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laplacian_sharpen_3x3_core_defines.svh"

module lsh_dp #(
  parameter int MAX_CHANNELS = 4,
  parameter int AddrW        = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire logic [AddrW-1:0]              item_addr_i,
  input  wire logic [lsh_pkg::SampleW-1:0]   item_sample_i,
  input  wire lsh_pkg::item_ctl_t            item_ctl_i,
  input  wire logic [lsh_pkg::ChanW-1:0]     ch_i,
  input  wire lsh_pkg::line_pair_t           rdata_i,
  output logic                               can_take_o,
  output logic                               we_o,
  output logic      [AddrW-1:0]              waddr_o,
  output lsh_pkg::line_pair_t                wdata_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [lsh_pkg::SampleW-1:0]   value_o,
  output logic                               frame_end_o
);

  localparam int WinDepth = 2 * MAX_CHANNELS;
  localparam int SW       = lsh_pkg::SampleW;
  localparam int SumW     = lsh_pkg::SumW;

  logic                 s1_valid_q, s1_valid_d;
  logic [AddrW-1:0]     s1_addr_q;
  logic [SW-1:0]        s1_sample_q;
  lsh_pkg::item_ctl_t   s1_ctl_q;
  logic [SW-1:0]        win_q   [WinDepth];
  logic [SW-1:0]        up_q    [MAX_CHANNELS];
  logic [SW-1:0]        below_q [MAX_CHANNELS];
  logic                 out_valid_q, out_valid_d;
  logic [SW-1:0]        out_value_q;
  logic                 out_end_q;
  logic                 s1_go, step;
  logic [SW-1:0]        centre, left, above, below;
  logic [SumW-1:0]      sum;
  logic [lsh_pkg::ChanW:0] ch2;

  assign s1_go      = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && s1_go;
  assign can_take_o = !s1_valid_q || s1_go;
  assign ch2        = {ch_i, 1'b0};

  // Taps one and two pixels back in the same channel.
  always_comb begin
    centre = '0;
    left   = '0;
    above  = '0;
    below  = '0;
    for (int k = 0; k < WinDepth; k++) begin
      if (32'(k) == 32'(ch_i) - 32'd1) begin
        centre = win_q[k];
      end
      if (32'(k) == 32'(ch2) - 32'd1) begin
        left = win_q[k];
      end
    end
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (32'(k) == 32'(ch_i) - 32'd1) begin
        above = up_q[k];
        below = below_q[k];
      end
    end
  end

  assign sum = SumW'({centre, 2'b00}) + SumW'(centre) - SumW'(above) - SumW'(below)
             - SumW'(left) - SumW'(rdata_i.middle);

  // Consecutive beats use different entries, except at the wrap to a new
  // frame with one channel, where the first read of the new frame sees the
  // word before the final write of the old one. That word only reaches the
  // window and the upper row during the first row, which feed border results.
  assign we_o    = step;
  assign waddr_o = s1_addr_q;
  assign wdata_o = '{upper: rdata_i.middle, middle: s1_sample_q};

  always_comb begin
    if (item_valid_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (step && s1_ctl_q.produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_addr_q   <= item_addr_i;
      s1_sample_q <= item_sample_i;
      s1_ctl_q    <= item_ctl_i;
    end
    if (step) begin
      win_q[0]   <= rdata_i.middle;
      up_q[0]    <= rdata_i.upper;
      below_q[0] <= s1_sample_q;
      for (int k = 1; k < WinDepth; k++) begin
        win_q[k] <= win_q[k-1];
      end
      for (int k = 1; k < MAX_CHANNELS; k++) begin
        up_q[k]    <= up_q[k-1];
        below_q[k] <= below_q[k-1];
      end
      if (s1_ctl_q.produce) begin
        out_value_q <= s1_ctl_q.border ? '0 : lsh_pkg::saturate(sum);
        out_end_q   <= s1_ctl_q.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign frame_end_o = out_end_q;

  `LSH_ASSERT_NEXT(a_result_lands, step && s1_ctl_q.produce, out_valid_q && (out_end_q == $past(s1_ctl_q.last)), "result lost between stage and output register")

endmodule

`default_nettype wire

// ===== hdl/laplacian_sharpen_3x3_core.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core
// Streaming 3x3 Laplacian sharpening of channel-interleaved 8-bit images.
// ----------------------------------------------------------------------------
// The core takes one component per clock unless the output stalls or a new
// configuration settles, and gives each interior component as 5*centre minus
// its four same-channel neighbours, saturated to 0..255, with 0 on the first
// and last rows and pixel columns. Both rows above the current one live in a
// single line buffer RAM of MAX_WIDTH*MAX_CHANNELS 16-bit words that is read
// and written back once per component, so the rate is one beat per cycle, set
// by that one read-modify-write per element. A beat passes a stage register and
// then the result register; a result leaves one row plus one pixel of input
// after its centre component, and drain beats push out the tail of the frame,
// with frame_end on its final component. A write to a known register restarts
// the frame and, as after reset, holds input off while row and frame sizes settle.
`default_nettype none
`include "laplacian_sharpen_3x3_core_defines.svh"

module laplacian_sharpen_3x3_core #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lsh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lsh_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [lsh_pkg::SampleW-1:0]   sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [lsh_pkg::SampleW-1:0]   value_o,
  output logic                               frame_end_o
);

  localparam int Depth  = MAX_WIDTH * MAX_CHANNELS;
  localparam int AddrW  = $clog2(Depth);
  localparam int ElemsW = $clog2(Depth + 1);
  localparam int TotalW = lsh_pkg::HeightW + ElemsW;

  logic [lsh_pkg::ChanW-1:0]   ch;
  logic [lsh_pkg::HeightW-1:0] rows;
  logic [ElemsW-1:0]           elems;
  logic [TotalW-1:0]           total;
  logic                        busy, restart, can_take;
  logic                        item_valid;
  logic [AddrW-1:0]            item_addr;
  logic [lsh_pkg::SampleW-1:0] item_sample;
  lsh_pkg::item_ctl_t          item_ctl;
  logic                        we;
  logic [AddrW-1:0]            waddr;
  lsh_pkg::line_pair_t         wdata, rdata;

  assign cfg_ready_o = 1'b1;

  lsh_cfg #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ElemsW       (ElemsW),
    .TotalW       (TotalW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ch_o        (ch),
    .rows_o      (rows),
    .elems_o     (elems),
    .total_o     (total),
    .busy_o      (busy),
    .restart_o   (restart)
  );

  lsh_seq #(
    .AddrW  (AddrW),
    .ElemsW (ElemsW),
    .TotalW (TotalW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .sample_i      (sample_i),
    .ch_i          (ch),
    .rows_i        (rows),
    .elems_i       (elems),
    .total_i       (total),
    .busy_i        (busy),
    .restart_i     (restart),
    .can_take_i    (can_take),
    .item_valid_o  (item_valid),
    .item_addr_o   (item_addr),
    .item_sample_o (item_sample),
    .item_ctl_o    (item_ctl)
  );

  lsh_ram #(
    .Width ($bits(lsh_pkg::line_pair_t)),
    .Depth (Depth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (item_valid),
    .raddr_i (item_addr),
    .rdata_o (rdata)
  );

  lsh_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AddrW        (AddrW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_addr_i   (item_addr),
    .item_sample_i (item_sample),
    .item_ctl_i    (item_ctl),
    .ch_i          (ch),
    .rdata_i       (rdata),
    .can_take_o    (can_take),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .frame_end_o   (frame_end_o)
  );

  // A read and a write meet at one entry only at the wrap to a new frame.
  `LSH_ASSERT_NOW(a_rw_wrap, item_valid && we && (item_addr == waddr), item_addr == '0, "overlap off frame wrap")

endmodule

`default_nettype wire

// ===== tb/sv/laplacian_sharpen_3x3_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core_tb
// Self-checking testbench of the streaming Laplacian sharpening core.
// ----------------------------------------------------------------------------
// Frames of many shapes, including clamped ones, are streamed through the
// core with drain bubbles, samples sent while draining and frames cut short
// by a register write. A scoreboard keeps its own line buffers and window,
// predicts every result beat from the accepted input beats and compares each
// result with the oldest prediction. Sender and receiver idle at random, in
// separate phases and then both; the receiver once holds off for a long spell.
// ----------------------------------------------------------------------------

module laplacian_sharpen_3x3_core_tb;

  localparam int MaxWidth    = 1024;
  localparam int MaxChannels = 4;
  localparam int LineDepth   = 4096;
  localparam int WindowDepth = 9;
  localparam int SettleWait  = 8;
  localparam int LongHold    = 600;
  localparam int CycleLimit  = 2_000_000;
  localparam int ReportLimit = 10;
  localparam logic [lsh_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  typedef enum int {
    StyleUniform,
    StyleExtremes,
    StyleSmooth
  } pattern_e;

  typedef struct packed {
    logic [lsh_pkg::SampleW-1:0] value;
    logic                        frame_end;
  } sharpened_t;

  class sharpen_scoreboard;
    logic [lsh_pkg::WidthW-1:0]  width_reg;
    logic [lsh_pkg::HeightW-1:0] height_reg;
    logic [lsh_pkg::ChanW-1:0]   chan_reg;
    logic [lsh_pkg::SampleW-1:0] upper_mem [LineDepth];
    logic [lsh_pkg::SampleW-1:0] middle_mem [LineDepth];
    logic [lsh_pkg::SampleW-1:0] window [WindowDepth];
    int                          row_pos;
    int                          elem_pos;
    int                          emitted;
    sharpened_t                  sharpened_q [$];
    int                          errors;

    function new();
      width_reg  = lsh_pkg::WidthW'(lsh_pkg::WidthReset);
      height_reg = lsh_pkg::HeightW'(lsh_pkg::HeightReset);
      chan_reg   = lsh_pkg::ChanW'(lsh_pkg::ChanReset);
      foreach (upper_mem[i]) begin
        upper_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      row_pos  = 0;
      elem_pos = 0;
      emitted  = 0;
    endfunction

    // Register contents are masked to their widths and then clamped.
    static function void frame_shape(input int w_raw, input int h_raw, input int ch_raw,
                                     output int elems, output int rows, output int chans);
      int w;
      w = w_raw & ((1 << lsh_pkg::WidthW) - 1);
      if (w < lsh_pkg::MinWidth) w = lsh_pkg::MinWidth;
      if (w > MaxWidth) w = MaxWidth;
      rows = h_raw & ((1 << lsh_pkg::HeightW) - 1);
      if (rows < lsh_pkg::MinHeight) rows = lsh_pkg::MinHeight;
      if (rows > lsh_pkg::MaxHeight) rows = lsh_pkg::MaxHeight;
      chans = ch_raw & ((1 << lsh_pkg::ChanW) - 1);
      if (chans < 1) chans = 1;
      if (chans > MaxChannels) chans = MaxChannels;
      elems = w * chans;
    endfunction

    function void set_register(input logic [lsh_pkg::CfgIdxW-1:0] idx,
                               input logic [lsh_pkg::CfgDataW-1:0] data);
      case (idx)
        lsh_pkg::RegWidth: begin
          width_reg = data[lsh_pkg::WidthW-1:0];
        end
        lsh_pkg::RegHeight: begin
          height_reg = data[lsh_pkg::HeightW-1:0];
        end
        lsh_pkg::RegChannels: begin
          chan_reg = data[lsh_pkg::ChanW-1:0];
        end
        default: begin
          return;
        end
      endcase
      restart();
    endfunction

    function void take_component(input lsh_pkg::cmd_e kind,
                                 input logic [lsh_pkg::SampleW-1:0] data);
      int                          elems, rows, chans, total, r, c, back, acc, k;
      logic [lsh_pkg::SampleW-1:0] v, above, below;
      logic                        last, border;
      sharpened_t                  res;
      frame_shape(width_reg, height_reg, chan_reg, elems, rows, chans);
      total = rows * elems;
      r = row_pos;
      c = elem_pos % elems;
      // A drain beat before the frame is complete is only a bubble.
      if (kind == lsh_pkg::CmdDrain && r < rows) return;
      v = (r >= rows) ? '0 : data;
      for (k = WindowDepth - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = middle_mem[c % LineDepth];
      above = '0;
      below = '0;
      if (c >= chans) begin
        back = (c - chans) % LineDepth;
        above = upper_mem[back];
        below = middle_mem[back];
        upper_mem[back] = window[chans];
      end
      middle_mem[c % LineDepth] = v;
      if ((r >= 1 && c >= chans) || r >= 2) begin
        last   = (emitted + 1 >= total);
        border = (c < 2 * chans) || (r == 1) || (r - 1 >= rows - 1);
        acc = 5 * int'(window[chans]) - int'(above) - int'(below)
              - int'(window[2 * chans]) - int'(window[0]);
        if (border || acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res.value     = acc[lsh_pkg::SampleW-1:0];
        res.frame_end = last;
        sharpened_q.push_back(res);
        if (last) begin
          restart();
          return;
        end
        emitted++;
      end
      c++;
      if (c >= elems) begin
        c = 0;
        r++;
      end
      row_pos  = r;
      elem_pos = c;
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= ReportLimit) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(input logic [lsh_pkg::SampleW-1:0] value,
                               input logic frame_end);
      sharpened_t want;
      if (sharpened_q.size() == 0) begin
        report($sformatf("result beat value %0d frame_end %0b with nothing expected",
                         value, frame_end));
        return;
      end
      want = sharpened_q.pop_front();
      if (value !== want.value)
        report($sformatf("value expected %0d, got %0d", want.value, value));
      if (frame_end !== want.frame_end)
        report($sformatf("frame_end expected %0b, got %0b", want.frame_end, frame_end));
    endfunction
  endclass

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lsh_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [lsh_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic                         cmd       = lsh_pkg::CmdSample;
  logic [lsh_pkg::SampleW-1:0]  sample    = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [lsh_pkg::SampleW-1:0]  value;
  logic                         frame_end;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;
  int cur_w, cur_h, cur_ch;

  sharpen_scoreboard sb = new();

  laplacian_sharpen_3x3_core #(
    .MAX_WIDTH   (MaxWidth),
    .MAX_CHANNELS(MaxChannels)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cmd_i      (cmd),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .value_o    (value),
    .frame_end_o(frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A long hold-off is requested by the stimulus and counted down here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_component(lsh_pkg::cmd_e'(cmd), sample);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_result(value, frame_end);
    end
  end

  task automatic send_item(input lsh_pkg::cmd_e kind,
                           input logic [lsh_pkg::SampleW-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= kind;
    sample   <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // The first edge lets the monitor log the last accepted beat before the
  // queue is looked at; the settle cycles cover bubbles still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.sharpened_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_register(input logic [lsh_pkg::CfgIdxW-1:0] idx,
                                input logic [lsh_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int w, input int h, input int ch);
    wait_drained();
    write_register(RegUnused, lsh_pkg::CfgDataW'($urandom));
    write_register(lsh_pkg::RegWidth, lsh_pkg::CfgDataW'(w));
    write_register(lsh_pkg::RegHeight, lsh_pkg::CfgDataW'(h));
    write_register(lsh_pkg::RegChannels, lsh_pkg::CfgDataW'(ch));
    cfg_valid <= 1'b0;
    cur_w  = w;
    cur_h  = h;
    cur_ch = ch;
  endtask

  task automatic send_frame(input pattern_e style, input int bubble_pct,
                            input bit pause_midway, inout int sent);
    int                          elems, rows, chans, comps, base, t, i;
    logic [lsh_pkg::SampleW-1:0] data;
    sharpen_scoreboard::frame_shape(cur_w, cur_h, cur_ch, elems, rows, chans);
    comps = elems * rows;
    base  = $urandom_range(255);
    for (i = 0; i < comps; i++) begin
      case (style)
        StyleExtremes: begin
          data = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        StyleSmooth: begin
          t = base + int'($urandom_range(40)) - 20;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          data = lsh_pkg::SampleW'(t);
        end
        default: begin
          data = lsh_pkg::SampleW'($urandom);
        end
      endcase
      if ($urandom_range(99) < bubble_pct)
        send_item(lsh_pkg::CmdDrain, lsh_pkg::SampleW'($urandom));
      send_item(lsh_pkg::CmdSample, data);
      sent++;
      if (pause_midway && i == comps / 2) wait_drained();
    end
    // The tail is one row plus one pixel; samples here count as drain beats.
    for (i = 0; i < elems + chans; i++) begin
      if ($urandom_range(3) == 0) send_item(lsh_pkg::CmdSample, lsh_pkg::SampleW'($urandom));
      else send_item(lsh_pkg::CmdDrain, lsh_pkg::SampleW'($urandom));
      sent++;
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int i, f, phase, sent;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset shape: a bubble and a few samples, cut short by the next write.
    send_item(lsh_pkg::CmdDrain, 8'h3C);
    for (i = 0; i < 20; i++) send_item(lsh_pkg::CmdSample, lsh_pkg::SampleW'($urandom));

    // Smallest frame, twice back to back: a bright centre saturates high, a dark
    // one saturates low. A bubble sits in the first, samples drain the second.
    configure(3, 3, 1);
    for (f = 0; f < 2; f++) begin
      for (i = 0; i < 9; i++) begin
        if (f == 0 && i == 3) send_item(lsh_pkg::CmdDrain, 8'hA5);
        send_item(lsh_pkg::CmdSample, ((i == 4) == (f == 0)) ? 8'hFF : 8'h00);
      end
      for (i = 0; i < 4; i++)
        send_item(f == 0 ? lsh_pkg::CmdDrain : lsh_pkg::CmdSample, 8'h5A);
    end

    // A frame cut short: the next register write restarts it.
    configure(3, 3, 1);
    for (i = 0; i < 5; i++) send_item(lsh_pkg::CmdSample, lsh_pkg::SampleW'($urandom));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 86;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 86;
        end
        default: begin
          sender_idle_pct    = 38;
          receiver_stall_pct = 38;
        end
      endcase
      sent = 0;
      if (phase == 0) begin
        // Every register below its range, then the largest shape cut short,
        // then a height below its range.
        configure(0, 0, 0);
        send_frame(StyleSmooth, 0, 1'b0, sent);
        configure(13'h1FFF, 8191, 7);
        for (i = 0; i < 40; i++) send_item(lsh_pkg::CmdSample, lsh_pkg::SampleW'($urandom));
        configure(7, 2, 2);
        send_frame(StyleExtremes, 0, 1'b0, sent);
        sent = 0;
      end
      while (sent < 150) begin
        configure($urandom_range(7), $urandom_range(5), $urandom_range(7));
        if (phase == 2 && sent == 0) hold_left = LongHold;
        send_frame(pattern_e'($urandom_range(2)), 10, phase == 1 && sent == 0, sent);
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.sharpened_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== laplacian_sharpen_3x3_core.f =====
+incdir+hdl
hdl/lsh_pkg.sv
hdl/lsh_ram.sv
hdl/lsh_cfg.sv
hdl/lsh_seq.sv
hdl/lsh_dp.sv
hdl/laplacian_sharpen_3x3_core.sv
tb/sv/laplacian_sharpen_3x3_core_tb.sv
